[src/pnrs_pkg.sv]
// Shared types and codes of the polynomial Newton root solver.
// No dependencies; used by pnrs_ctrl, pnrs_dp and the top level.
`timescale 1ns / 1ps
package pnrs_pkg;

  localparam int IDX_W = 5;  // carries any coefficient index up to order 31

  typedef logic [3:0] cmd_op_t;

  localparam cmd_op_t OP_NONE   = 4'd0;
  localparam cmd_op_t OP_LOAD   = 4'd1;
  localparam cmd_op_t OP_SOLVE  = 4'd2;
  localparam cmd_op_t OP_INIT   = 4'd3;
  localparam cmd_op_t OP_MUL_P  = 4'd4;
  localparam cmd_op_t OP_WB_P   = 4'd5;
  localparam cmd_op_t OP_MUL_F  = 4'd6;
  localparam cmd_op_t OP_WB_F   = 4'd7;
  localparam cmd_op_t OP_MUL_W  = 4'd8;
  localparam cmd_op_t OP_WB_W   = 4'd9;
  localparam cmd_op_t OP_MUL_D  = 4'd10;
  localparam cmd_op_t OP_WB_D   = 4'd11;
  localparam cmd_op_t OP_DIV    = 4'd12;
  localparam cmd_op_t OP_UPDATE = 4'd13;
  localparam cmd_op_t OP_OUT    = 4'd14;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOT_CONV   = 2'd1;
  localparam logic [1:0] ST_ZERO_DERIV = 2'd2;

  localparam logic [1:0] REG_ITER  = 2'd0;
  localparam logic [1:0] REG_TOL   = 2'd1;
  localparam logic [1:0] REG_ORDER = 2'd2;

  localparam logic MODE_LOAD = 1'b0;

  typedef struct packed {
    cmd_op_t            op;
    logic [IDX_W-1:0]   idx;
    logic               zero_deriv;
  } dp_cmd_t;

  typedef struct packed {
    logic deriv_zero;
    logic div_busy;
    logic out_busy;
  } dp_stat_t;

endpackage

[src/polynomial_newton_root_solver.sv]
// Newton-Raphson polynomial root solver in signed fixed point (Q16.16 by default).
// A load beat (mode 0) writes one coefficient into the store and gives no result;
// a solve beat (mode 1) brings the start value and, after iteration_count Newton
// steps, gives one result beat with the root, the residual f(root) and a status
// (ok, residual above root_tolerance, or zero derivative - iteration then stops).
// A load is taken while the sequencer is idle. A solve is worked through one shared
// 32x32 multiplier with a registered product and a restoring divider giving one
// quotient bit a cycle: each step evaluates f and f', divides and updates, and a
// final evaluation of f comes before the result is written. One solve is in flight
// at a time; a finished result waits in the output register while loads are still
// taken.
// Depends on pnrs_pkg, pnrs_ctrl and pnrs_dp.
`timescale 1ns / 1ps
module polynomial_newton_root_solver #(
  parameter int MAX_ORDER = 10,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode,
  input  logic [3:0]         coeff_index,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] root,
  output logic signed [31:0] residual,
  output logic [1:0]         status
);
  localparam int IW = $clog2(MAX_ORDER + 1);

  logic [7:0]          iteration_count;
  logic [30:0]         root_tolerance;
  logic [3:0]          poly_order;
  logic [IW-1:0]       order_eff;
  pnrs_pkg::dp_cmd_t   cmd;
  pnrs_pkg::dp_stat_t  stat;

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      iteration_count <= 8'd10;
      root_tolerance <= 31'd66;
      poly_order <= 4'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pnrs_pkg::REG_ITER:  iteration_count <= cfg_data[7:0];
        pnrs_pkg::REG_TOL:   root_tolerance <= cfg_data;
        pnrs_pkg::REG_ORDER: poly_order <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // clamp the order to what the store holds
  assign order_eff = (32'(poly_order) > MAX_ORDER) ? IW'(MAX_ORDER) : IW'(poly_order);

  pnrs_ctrl #(.MAX_ORDER(MAX_ORDER)) u_ctrl (
    .clk, .rst, .in_valid, .mode, .in_ready,
    .iteration_count, .order_eff, .stat, .cmd
  );

  pnrs_dp #(.MAX_ORDER(MAX_ORDER), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst, .cmd, .stat, .coeff_index, .value, .root_tolerance,
    .out_valid, .out_ready, .root, .residual, .status
  );

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == pnrs_pkg::ST_OK || status == pnrs_pkg::ST_NOT_CONV ||
                   status == pnrs_pkg::ST_ZERO_DERIV))
    else $error("undefined status code");

  a_ok_within_tol: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == pnrs_pkg::ST_OK) |->
      (residual >= -$signed({1'b0, root_tolerance}) &&
       residual <= $signed({1'b0, root_tolerance})))
    else $error("ok status with residual above tolerance");

  a_div_blocks_input: assert property (@(posedge clk) disable iff (rst)
    stat.div_busy |-> !in_ready)
    else $error("input taken while the divider runs");

endmodule

[src/pnrs_ctrl.sv]
// Sequencer of the root solver: steps through evaluation, division and update.
// Depends on pnrs_pkg; drives pnrs_dp by command, reads its status.
`timescale 1ns / 1ps
module pnrs_ctrl #(
  parameter int MAX_ORDER = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                mode,
  output logic                in_ready,
  input  logic [7:0]          iteration_count,
  input  logic [$clog2(MAX_ORDER+1)-1:0] order_eff,
  input  pnrs_pkg::dp_stat_t  stat,
  output pnrs_pkg::dp_cmd_t   cmd
);
  localparam int IW = $clog2(MAX_ORDER + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_INIT   = 4'd1;
  localparam logic [3:0] S_MUL_P  = 4'd2;
  localparam logic [3:0] S_WB_P   = 4'd3;
  localparam logic [3:0] S_MUL_F  = 4'd4;
  localparam logic [3:0] S_WB_F   = 4'd5;
  localparam logic [3:0] S_MUL_W  = 4'd6;
  localparam logic [3:0] S_WB_W   = 4'd7;
  localparam logic [3:0] S_MUL_D  = 4'd8;
  localparam logic [3:0] S_WB_D   = 4'd9;
  localparam logic [3:0] S_END    = 4'd10;
  localparam logic [3:0] S_DIV_ST = 4'd11;
  localparam logic [3:0] S_DIV    = 4'd12;
  localparam logic [3:0] S_UPD    = 4'd13;
  localparam logic [3:0] S_OUT    = 4'd14;

  logic [3:0]    state, state_next;
  logic [IW-1:0] i, order;
  logic [7:0]    k, iters;
  logic          final_pass, zd;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd.op = pnrs_pkg::OP_NONE;
    cmd.idx = pnrs_pkg::IDX_W'(i);
    cmd.zero_deriv = zd;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = (mode == pnrs_pkg::MODE_LOAD) ? pnrs_pkg::OP_LOAD : pnrs_pkg::OP_SOLVE;
          if (mode != pnrs_pkg::MODE_LOAD) state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.op = pnrs_pkg::OP_INIT;
        state_next = S_MUL_F;
      end
      S_MUL_P: begin
        cmd.op = pnrs_pkg::OP_MUL_P;
        state_next = S_WB_P;
      end
      S_WB_P: begin
        cmd.op = pnrs_pkg::OP_WB_P;
        state_next = S_MUL_F;
      end
      S_MUL_F: begin
        cmd.op = pnrs_pkg::OP_MUL_F;
        state_next = S_WB_F;
      end
      S_WB_F: begin
        cmd.op = pnrs_pkg::OP_WB_F;
        priority if (!final_pass && i < order) state_next = S_MUL_W;
        else if (i == order) state_next = S_END;
        else state_next = S_MUL_P;
      end
      S_MUL_W: begin
        cmd.op = pnrs_pkg::OP_MUL_W;
        state_next = S_WB_W;
      end
      S_WB_W: begin
        cmd.op = pnrs_pkg::OP_WB_W;
        state_next = S_MUL_D;
      end
      S_MUL_D: begin
        cmd.op = pnrs_pkg::OP_MUL_D;
        state_next = S_WB_D;
      end
      S_WB_D: begin
        cmd.op = pnrs_pkg::OP_WB_D;
        state_next = S_MUL_P;
      end
      S_END: begin
        priority if (final_pass) state_next = S_OUT;
        else if (stat.deriv_zero) state_next = S_INIT;
        else state_next = S_DIV_ST;
      end
      S_DIV_ST: begin
        cmd.op = pnrs_pkg::OP_DIV;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (!stat.div_busy) state_next = S_UPD;
      end
      S_UPD: begin
        cmd.op = pnrs_pkg::OP_UPDATE;
        state_next = S_INIT;
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.op = pnrs_pkg::OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      final_pass <= 1'b0;
      zd <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_valid && mode != pnrs_pkg::MODE_LOAD) begin
        zd <= 1'b0;
        final_pass <= (iteration_count == 8'd0);
      end
      if (state == S_END && !final_pass && stat.deriv_zero) begin
        zd <= 1'b1;
        final_pass <= 1'b1;
      end
      if (state == S_UPD && (k + 8'd1) == iters) final_pass <= 1'b1;
    end
  end

  // datapath indices and counters: no reset needed, loaded at solve start
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      k <= 8'd0;
      iters <= iteration_count;
      order <= order_eff;
    end
    if (state == S_INIT) i <= '0;
    if (state == S_WB_P) i <= i;
    if (state == S_WB_F && i != order && (final_pass || i >= order)) i <= i + 1'b1;
    if (state == S_WB_D) i <= i + 1'b1;
    if (state == S_UPD) k <= k + 8'd1;
  end

endmodule

[src/pnrs_dp.sv]
// Datapath of the root solver: coefficient store, shared multiplier, divider.
// Depends on pnrs_pkg; commanded by pnrs_ctrl.
`timescale 1ns / 1ps
module pnrs_dp #(
  parameter int MAX_ORDER = 10,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  pnrs_pkg::dp_cmd_t   cmd,
  output pnrs_pkg::dp_stat_t  stat,
  input  logic [3:0]          coeff_index,
  input  logic signed [31:0]  value,
  input  logic [30:0]         root_tolerance,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  root,
  output logic signed [31:0]  residual,
  output logic [1:0]          status
);
  localparam int IW = $clog2(MAX_ORDER + 1);
  localparam int DW = 32 + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);
  localparam logic signed [64:0] HALF = 65'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [31:0] ONE  = 32'sd1 <<< FRAC_BITS;

  function automatic logic signed [31:0] sat65(input logic signed [64:0] v);
    if (v > 65'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -65'sh0_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s[32] != s[31]) return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) - 33'(b);
    if (s[32] != s[31]) return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    return s[31:0];
  endfunction

  logic signed [31:0] coef [0:MAX_ORDER];
  logic signed [31:0] x, pw, acc_f, acc_d, w;
  logic signed [31:0] ma, mb, q_sat, qmul_res;
  logic signed [63:0] prod;
  logic signed [64:0] rnd;
  logic [IW-1:0]      addr;
  logic [DW-1:0]      dq;
  logic [31:0]        dv, amag, bmag;
  logic [32:0]        rem, rem_sh, res_mag;
  logic [CW-1:0]      cnt;
  logic               neg;

  // operand selection for the shared multiplier
  always_comb begin
    addr = (cmd.op == pnrs_pkg::OP_MUL_W) ? cmd.idx[IW-1:0] + 1'b1 : cmd.idx[IW-1:0];
    ma = pw;
    mb = x;
    unique case (cmd.op)
      pnrs_pkg::OP_MUL_F: begin ma = coef[addr]; mb = pw; end
      pnrs_pkg::OP_MUL_W: begin ma = 32'(addr); mb = coef[addr]; end
      pnrs_pkg::OP_MUL_D: begin ma = w; mb = pw; end
      default: begin ma = pw; mb = x; end
    endcase
  end

  assign rnd = (65'(prod) + HALF) >>> FRAC_BITS;
  assign qmul_res = sat65(rnd);

  // divider result: saturate the signed quotient
  always_comb begin
    if (neg) q_sat = (dq > DW'(32'h8000_0000)) ? 32'sh8000_0000 : -$signed(dq[31:0]);
    else q_sat = (dq > DW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(dq[31:0]);
  end

  assign amag = acc_f[31] ? 32'(-acc_f) : 32'(acc_f);
  assign bmag = acc_d[31] ? 32'(-acc_d) : 32'(acc_d);
  assign rem_sh = {rem[31:0], dq[DW-1]};
  assign res_mag = acc_f[31] ? 33'(-33'(acc_f)) : 33'(acc_f);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= MAX_ORDER; j++) coef[j] <= '0;
    end else if (cmd.op == pnrs_pkg::OP_LOAD && 32'(coeff_index) <= MAX_ORDER) begin
      coef[IW'(coeff_index)] <= value;
    end
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    unique case (cmd.op)
      pnrs_pkg::OP_SOLVE:  x <= value;
      pnrs_pkg::OP_INIT: begin
        pw <= ONE;
        acc_f <= '0;
        acc_d <= '0;
      end
      pnrs_pkg::OP_WB_P:   pw <= qmul_res;
      pnrs_pkg::OP_WB_F:   acc_f <= sat_add(acc_f, qmul_res);
      pnrs_pkg::OP_WB_W:   w <= sat65(65'(prod));
      pnrs_pkg::OP_WB_D:   acc_d <= sat_add(acc_d, qmul_res);
      pnrs_pkg::OP_UPDATE: x <= sat_sub(x, q_sat);
      default: ;
    endcase
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.op == pnrs_pkg::OP_DIV) begin
      cnt <= CW'(DW);
      neg <= acc_f[31] ^ acc_d[31];
      dq <= {amag, {FRAC_BITS{1'b0}}};
      dv <= bmag;
      rem <= '0;
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
      if (rem_sh >= {1'b0, dv}) begin
        rem <= rem_sh - {1'b0, dv};
        dq <= {dq[DW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        dq <= {dq[DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == pnrs_pkg::OP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == pnrs_pkg::OP_OUT) begin
      root <= x;
      residual <= acc_f;
      priority if (cmd.zero_deriv) status <= pnrs_pkg::ST_ZERO_DERIV;
      else if (res_mag > 33'(root_tolerance)) status <= pnrs_pkg::ST_NOT_CONV;
      else status <= pnrs_pkg::ST_OK;
    end
  end

  assign stat.deriv_zero = (acc_d == '0);
  assign stat.div_busy = (cnt != '0);
  assign stat.out_busy = out_valid;

endmodule

[verif/pnrs_checker.sv]
// Checker for the polynomial Newton root solver: watches the config, input and
// result channels, predicts each solve in Q16.16 and compares field by field.
// Depends on pnrs_pkg for the status and register codes.
`timescale 1ns / 1ps
module pnrs_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               mode,
  input  logic [3:0]         coeff_index,
  input  logic signed [31:0] value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] root,
  input  logic signed [31:0] residual,
  input  logic [1:0]         status,
  output int                 errors,
  output int                 pending,
  output int                 solves_checked
);
  localparam int FRAC = 16;
  localparam int TOP_IDX = 10;

  typedef struct {
    logic signed [31:0] root;
    logic signed [31:0] residual;
    logic [1:0]         status;
  } solution_t;

  solution_t  solution_q[$];
  longint     coef[0:TOP_IDX];
  logic [7:0] steps;
  logic [30:0] tolerance;
  logic [3:0] order_reg;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // round half up, then floor by arithmetic shift
  function automatic longint q_mul(longint a, longint b);
    return sat32((a * b + (64'sd1 <<< (FRAC - 1))) >>> FRAC);
  endfunction

  function automatic void poly_and_slope(input longint x, input int ord,
                                         output longint f, output longint df);
    longint pw[0:TOP_IDX];
    longint w;
    f = 0;
    df = 0;
    for (int i = 0; i <= ord; i++) begin
      pw[i] = (i == 0) ? (64'sd1 <<< FRAC) : q_mul(pw[i-1], x);
      f = sat32(f + q_mul(coef[i], pw[i]));
    end
    for (int i = 0; i < ord; i++) begin
      w = sat32(longint'(i + 1) * coef[i+1]);
      df = sat32(df + q_mul(w, pw[i]));
    end
  endfunction

  function automatic solution_t newton_solve(longint start);
    solution_t s;
    longint x, f, df, mag;
    int ord;
    ord = (order_reg > TOP_IDX) ? TOP_IDX : int'(order_reg);
    x = start;
    s.status = pnrs_pkg::ST_OK;
    for (int k = 0; k < int'(steps); k++) begin
      poly_and_slope(x, ord, f, df);
      if (df == 0) begin
        s.status = pnrs_pkg::ST_ZERO_DERIV;
        break;
      end
      x = sat32(x - sat32((f <<< FRAC) / df));
    end
    poly_and_slope(x, ord, f, df);
    mag = (f < 0) ? -f : f;
    if (s.status != pnrs_pkg::ST_ZERO_DERIV && mag > longint'(tolerance))
      s.status = pnrs_pkg::ST_NOT_CONV;
    s.root = x[31:0];
    s.residual = f[31:0];
    return s;
  endfunction

  always @(posedge clk) begin
    solution_t want;
    if (rst) begin
      steps = 8'd10;
      tolerance = 31'd66;
      order_reg = 4'd10;
      for (int i = 0; i <= TOP_IDX; i++) coef[i] = 0;
      solution_q.delete();
      errors = 0;
      pending = 0;
      solves_checked = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pnrs_pkg::REG_ITER:  steps = cfg_data[7:0];
          pnrs_pkg::REG_TOL:   tolerance = cfg_data;
          pnrs_pkg::REG_ORDER: order_reg = cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (mode == pnrs_pkg::MODE_LOAD) begin
          if (coeff_index <= TOP_IDX) coef[coeff_index] = longint'(value);
        end else begin
          solution_q.push_back(newton_solve(longint'(value)));
        end
      end
      if (out_valid && out_ready) begin
        if (solution_q.size() == 0) begin
          $error("result beat with nothing expected: root %0d residual %0d status %0d",
                 root, residual, status);
          errors++;
        end else begin
          want = solution_q.pop_front();
          solves_checked++;
          if (root !== want.root) begin
            $error("root: expected %0d, got %0d", want.root, root);
            errors++;
          end
          if (residual !== want.residual) begin
            $error("residual: expected %0d, got %0d", want.residual, residual);
            errors++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
          end
        end
      end
      pending = solution_q.size();
    end
  end

endmodule

[verif/tb_polynomial_newton_root_solver.sv]
// Top of the root solver testbench: drives config writes, load and solve beats
// and the result back-pressure, and gives the verdict.
// Depends on pnrs_pkg, pnrs_checker and the polynomial_newton_root_solver RTL.
`timescale 1ns / 1ps
module tb_polynomial_newton_root_solver;
  localparam logic       MODE_SOLVE = 1'b1;
  localparam logic [1:0] REG_SPARE  = 2'd3;     // unmapped register index
  localparam int         ONE        = 65536;    // 1.0 in Q16.16
  localparam int         STALL_LIMIT = 300000;  // a 255-step solve plus the long hold
  localparam int         HOLD_LEN   = 2000;     // receiver hold-off, in cycles

  logic               clk, rst;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [30:0]        cfg_data;
  logic               in_valid, in_ready;
  logic               mode;
  logic [3:0]         coeff_index;
  logic signed [31:0] value;
  logic               out_valid, out_ready;
  logic signed [31:0] root, residual;
  logic [1:0]         status;

  int errors, pending, solves_checked;
  int idle_pct;          // idling odds in percent, both sides
  int hold_cycles;       // long receiver hold-off, in cycles
  bit hold_req;
  bit hold_done;
  int quiet_cycles;
  int beats_sent;

  polynomial_newton_root_solver dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .coeff_index(coeff_index), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .root(root), .residual(residual), .status(status)
  );

  pnrs_checker chk (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .coeff_index(coeff_index), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .root(root), .residual(residual), .status(status),
    .errors(errors), .pending(pending), .solves_checked(solves_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off on request, so a finished
  // result sits in the output register, a second solve backs up behind it and
  // the input stalls while the sender keeps offering.
  initial begin
    out_ready = 1'b0;
    hold_cycles = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && hold_req) begin
        hold_done = 1'b1;
        hold_cycles = HOLD_LEN;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a beat.
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no beat for %0d cycles, %0d solves outstanding",
                 quiet_cycles, pending);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Offer one beat; valid stays up across back-to-back beats.
  task automatic send_beat(logic m, logic [3:0] idx, logic signed [31:0] v);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= m;
    coeff_index <= idx;
    value       <= v;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  // Drain outstanding solves and let a trailing load settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [30:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_solver(int steps, int tol, int ord);
    drain();
    write_reg(pnrs_pkg::REG_ITER, 31'(steps));
    write_reg(pnrs_pkg::REG_TOL, 31'(tol));
    write_reg(pnrs_pkg::REG_ORDER, 31'(ord));
  endtask

  // Mostly modest coefficients so iterations stay meaningful; some full range.
  function automatic logic signed [31:0] rand_q16();
    case ($urandom_range(3))
      0:       return $urandom();
      1:       return $signed($urandom_range(2 * ONE)) - ONE;
      default: return $signed($urandom_range(8 * ONE)) - 4 * ONE;
    endcase
  endfunction

  initial begin
    int steps, tol, ord, n_solve;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    mode = pnrs_pkg::MODE_LOAD;
    coeff_index = '0;
    value = '0;
    idle_pct = 7;
    beats_sent = 0;
    hold_req = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty store at reset settings gives a zero derivative.
    send_beat(MODE_SOLVE, 4'd0, ONE);
    // x^2 - 2 from 1.0, order 2
    send_beat(pnrs_pkg::MODE_LOAD, 4'd0, -2 * ONE);
    send_beat(pnrs_pkg::MODE_LOAD, 4'd2, ONE);
    send_beat(pnrs_pkg::MODE_LOAD, 4'd15, 32'h7fffffff);   // out of range, dropped
    send_beat(pnrs_pkg::MODE_LOAD, 4'd11, 32'h80000000);   // out of range, dropped
    set_solver(8, 66, 2);
    write_reg(REG_SPARE, 31'h7fffffff);          // unmapped, no effect
    send_beat(MODE_SOLVE, 4'd5, ONE);
    send_beat(MODE_SOLVE, 4'd0, 0);              // slope zero at the origin
    send_beat(MODE_SOLVE, 4'd0, 32'h7fffffff);
    send_beat(MODE_SOLVE, 4'd0, 32'h80000000);
    set_solver(0, 0, 2);                         // no steps, zero tolerance
    send_beat(MODE_SOLVE, 4'd0, 3 * ONE);
    set_solver(6, 31'h7fffffff, 0);              // order zero
    send_beat(MODE_SOLVE, 4'd0, ONE);
    // extreme coefficients in slots 10 and 9, one in slot 1, then order above the store
    send_beat(pnrs_pkg::MODE_LOAD, 4'd10, 32'h7fffffff);
    send_beat(pnrs_pkg::MODE_LOAD, 4'd9, 32'h80000000);
    send_beat(pnrs_pkg::MODE_LOAD, 4'd1, ONE);
    set_solver(3, 66, 15);
    // hold the receiver off while three solves queue up behind each other
    hold_req = 1'b1;
    send_beat(MODE_SOLVE, 4'd0, ONE / 2);
    send_beat(MODE_SOLVE, 4'd0, -ONE / 2);
    send_beat(MODE_SOLVE, 4'd0, 2 * ONE);
    set_solver(255, 1000, 1);                    // deepest iteration count
    send_beat(MODE_SOLVE, 4'd0, 32'h12345678);

    // Random phases; phase 3 runs without any idling.
    for (int ph = 0; ph < 14; ph++) begin
      case ($urandom_range(3))
        0:       tol = 0;
        1:       tol = 31'h7fffffff;
        2:       tol = $urandom_range(2000);
        default: tol = $urandom_range(31'h7fffffff);
      endcase
      steps = (ph == 9) ? 255 : $urandom_range(12);
      ord = (ph % 5 == 0) ? $urandom_range(15) : $urandom_range(1, 10);
      set_solver(steps, tol, ord);
      idle_pct = (ph == 3) ? 0 : 7;
      n_solve = 0;
      for (int i = 0; i < 70; i++) begin
        // solves are a minority, and few when every solve is slow
        if ($urandom_range(99) < ((steps > 50) ? 2 : 10) || (i == 69 && n_solve == 0)) begin
          send_beat(MODE_SOLVE, 4'($urandom()), rand_q16());
          n_solve++;
        end else if ($urandom_range(19) == 0) begin
          send_beat(pnrs_pkg::MODE_LOAD, 4'($urandom_range(11, 15)), $urandom());
        end else begin
          send_beat(pnrs_pkg::MODE_LOAD, 4'($urandom_range(10)), rand_q16());
        end
      end
    end

    drain();
    repeat (200) @(posedge clk);
    $display("Sent %0d beats over 14 random settings plus directed cases;", beats_sent);
    $display("checked %0d solve results incl. zero-slope, no-step and saturating cases.",
             solves_checked);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
